/* src/sbeq_pkg.sv */
// Shared types, constants and saturation helpers for the stereo biquad equalizer.
package sbeq_pkg;

  localparam int STAGE_COUNT_DEF = 5;
  localparam int BLOCK_LIMIT_DEF = 512;
  localparam int CNT_W = 10;
  localparam int STG_W = 3;
  localparam int COEF_W = 26;
  localparam int ADDR_W = 5;

  // register map index (byte address / 4)
  localparam logic [2:0] REG_HPF   = 3'd0;
  localparam logic [2:0] REG_LPF   = 3'd1;
  localparam logic [2:0] REG_GAIN  = 3'd2;
  localparam logic [2:0] REG_MUTE  = 3'd3;
  localparam logic [2:0] REG_DECAY = 3'd4;

  // biquad step within one stage
  localparam logic [2:0] PH_B0X  = 3'd0;
  localparam logic [2:0] PH_YOUT = 3'd1;
  localparam logic [2:0] PH_A1Y  = 3'd2;
  localparam logic [2:0] PH_Z1   = 3'd3;
  localparam logic [2:0] PH_A2Y  = 3'd4;
  localparam logic [2:0] PH_Z2   = 3'd5;

  // coefficient position within a stage
  localparam int POS_B0 = 0;
  localparam int POS_B1 = 1;
  localparam int POS_B2 = 2;
  localparam int POS_A1 = 3;
  localparam int POS_A2 = 4;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MAC,
    OP_GAIN,
    OP_MAG,
    OP_QUANT,
    OP_OUT,
    OP_METER
  } lane_op_t;

  typedef struct packed {
    lane_op_t           op;
    logic [STG_W-1:0]   stage;
    logic [2:0]         phase;
    logic               blk_end;
    logic [CNT_W-1:0]   blk_count;
  } ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    if (v > 42'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -42'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
    if (v > 42'sd549755813887) begin
      return 40'sh7fffffffff;
    end else if (v < -42'sd549755813888) begin
      return 40'sh8000000000;
    end
    return v[39:0];
  endfunction

endpackage

/* src/sbeq_lane.sv */
// One channel lane: biquad cascade on a shared multiplier, output gain and quantizer.
module sbeq_lane #(
  parameter int STAGE_COUNT = sbeq_pkg::STAGE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sbeq_pkg::ctl_t                    ctl,
  input  logic signed [sbeq_pkg::COEF_W-1:0] coef,
  input  logic signed [15:0]                sample,
  input  logic [16:0]                       gain,
  input  logic                              mute,
  output logic signed [15:0]                out_sample,
  output logic [15:0]                       level
);
  import sbeq_pkg::*;

  localparam int SW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

  logic signed [31:0] x_r;
  logic signed [31:0] y_r;
  logic signed [57:0] prod_r;
  logic signed [41:0] acc_r;
  logic signed [39:0] z1_r [STAGE_COUNT];
  logic signed [39:0] z2_r [STAGE_COUNT];
  logic               neg_r;
  logic [34:0]        mag_r;
  logic [15:0]        level_r;
  logic signed [15:0] out_r;

  logic signed [31:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [57:0] mul_p;
  logic signed [34:0] fl_p;
  logic signed [34:0] gv;
  logic [34:0]        gmag;
  logic [23:0]        magc;
  logic [14:0]        oq;
  logic [SW-1:0]      zi;

  assign zi   = ctl.stage[SW-1:0];
  assign fl_p = prod_r[57:23];
  assign gv   = prod_r[49:15];
  assign gmag = gv[34] ? 35'(-gv) : 35'(gv);
  assign magc = (mag_r > 35'd8388608) ? 24'h800000 : mag_r[23:0];
  assign oq   = prod_r[37:23];

  always_comb begin
    mul_a = x_r;
    mul_b = coef;
    case (ctl.op)
      OP_MAC: begin
        if (ctl.phase == PH_A1Y || ctl.phase == PH_A2Y) begin
          mul_a = y_r;
        end
      end
      OP_GAIN: begin
        mul_b = signed'({9'b0, gain});
      end
      OP_QUANT: begin
        mul_a = signed'({8'b0, magc});
        mul_b = 26'sd32767;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = 58'(mul_a) * 58'(mul_b);

  // datapath registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        x_r <= {{8{sample[15]}}, sample, 8'b0};
      end
      OP_MAC: begin
        prod_r <= mul_p;
        case (ctl.phase)
          PH_YOUT: y_r   <= sat32(42'(fl_p) + 42'(z1_r[zi]));
          PH_A1Y:  acc_r <= 42'(fl_p) + 42'(z2_r[zi]);
          PH_A2Y:  acc_r <= 42'(fl_p);
          PH_Z2:   x_r   <= y_r;
          default: begin
          end
        endcase
      end
      OP_GAIN: begin
        prod_r <= mul_p;
      end
      OP_MAG: begin
        neg_r   <= gv[34];
        mag_r   <= gmag;
        level_r <= (|gmag[34:25]) ? 16'hffff : gmag[24:9];
      end
      OP_QUANT: begin
        prod_r <= mul_p;
      end
      OP_OUT: begin
        if (mute) begin
          out_r <= '0;
        end else if (neg_r) begin
          out_r <= -signed'({1'b0, oq});
        end else begin
          out_r <= signed'({1'b0, oq});
        end
      end
      default: begin
      end
    endcase
  end

  // delay state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGE_COUNT; i++) begin
        z1_r[i] <= '0;
        z2_r[i] <= '0;
      end
    end else if (ctl.op == OP_MAC) begin
      if (ctl.phase == PH_Z1) begin
        z1_r[zi] <= sat40(acc_r - 42'(fl_p));
      end
      if (ctl.phase == PH_Z2) begin
        z2_r[zi] <= sat40(acc_r - 42'(fl_p));
      end
    end
  end

  assign out_sample = out_r;
  assign level      = level_r;

endmodule

/* src/sbeq_meter.sv */
// Level meter for one channel: square sum, block peak, divider, square root, held peak.
module sbeq_meter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       blk_end,
  input  logic [sbeq_pkg::CNT_W-1:0] blk_count,
  input  logic [15:0]                level,
  input  logic [15:0]                decay,
  output logic                       done,
  output logic [15:0]                rms,
  output logic [15:0]                peak
);
  import sbeq_pkg::*;

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_SQ   = 6'b000010,
    M_ACC  = 6'b000100,
    M_DIV  = 6'b001000,
    M_SQRT = 6'b010000,
    M_HOLD = 6'b100000
  } mstate_t;

  mstate_t          state_r, state_nxt;
  logic             end_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      sq_r;
  logic [47:0]      sum_r;
  logic [15:0]      bpeak_r;
  logic [15:0]      held_r;
  logic [15:0]      rms_r;
  logic [47:0]      dq_r;
  logic [CNT_W-1:0] rem_r;
  logic [25:0]      srem_r;
  logic [23:0]      root_r;
  logic [5:0]       iter_r;
  logic             done_r;

  logic [48:0]      sum_ext;
  logic [47:0]      sum_sat;
  logic [CNT_W:0]   dtrial;
  logic             dge;
  logic [27:0]      scat;
  logic [27:0]      strial;
  logic             sge;
  logic [31:0]      dprod;
  logic [15:0]      decayed;

  assign sum_ext = {1'b0, sum_r} + 49'(sq_r);
  assign sum_sat = sum_ext[48] ? '1 : sum_ext[47:0];
  assign dtrial  = {rem_r, dq_r[47]};
  assign dge     = dtrial >= {1'b0, cnt_r};
  assign scat    = {srem_r, dq_r[47:46]};
  assign strial  = 28'({root_r, 2'b01});
  assign sge     = scat >= strial;
  assign dprod   = held_r * decay;
  assign decayed = dprod[31:16];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      M_IDLE:  if (start) state_nxt = M_SQ;
      M_SQ:    state_nxt = M_ACC;
      M_ACC:   state_nxt = end_r ? M_DIV : M_IDLE;
      M_DIV:   if (iter_r == 6'd47) state_nxt = M_SQRT;
      M_SQRT:  if (iter_r == 6'd23) state_nxt = M_HOLD;
      M_HOLD:  state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      sum_r   <= '0;
      bpeak_r <= '0;
      held_r  <= '0;
      done_r  <= 1'b0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (start) begin
            end_r <= blk_end;
            cnt_r <= blk_count;
          end
        end
        M_SQ: begin
          sq_r <= level * level;
        end
        M_ACC: begin
          sum_r <= sum_sat;
          if (sq_r != 32'd0 && level > bpeak_r) begin
            bpeak_r <= level;
          end
          dq_r   <= sum_sat;
          rem_r  <= '0;
          iter_r <= '0;
          if (!end_r) begin
            done_r <= 1'b1;
          end
        end
        M_DIV: begin
          rem_r  <= dge ? CNT_W'(dtrial - {1'b0, cnt_r}) : dtrial[CNT_W-1:0];
          dq_r   <= {dq_r[46:0], dge};
          iter_r <= (iter_r == 6'd47) ? 6'd0 : iter_r + 6'd1;
          srem_r <= '0;
          root_r <= '0;
        end
        M_SQRT: begin
          srem_r <= sge ? 26'(scat - strial) : scat[25:0];
          root_r <= {root_r[22:0], sge};
          dq_r   <= {dq_r[45:0], 2'b00};
          iter_r <= (iter_r == 6'd23) ? 6'd0 : iter_r + 6'd1;
        end
        M_HOLD: begin
          rms_r   <= (|root_r[23:16]) ? 16'hffff : root_r[15:0];
          held_r  <= (bpeak_r > decayed) ? bpeak_r : decayed;
          sum_r   <= '0;
          bpeak_r <= '0;
          done_r  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign done = done_r;
  assign rms  = rms_r;
  assign peak = held_r;

  // divider and root run only on a block end
  a_div_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == M_DIV) |-> end_r)
    else $error("meter divides without block end");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == M_IDLE))
    else $error("meter started while busy");
  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == M_HOLD) |=> done_r)
    else $error("meter report not flagged");

endmodule

/* src/stereo_biquad_eq_chain_with_meter.sv */
// Top level: sequencer, coefficient memory, config registers, two lanes and result merge.
//
// Stereo equalizer with level meter. Each input transaction is either a coefficient
// write (in_action = 1, taken while idle, no result) or a stereo sample pair
// (in_action = 0, one result). Left and right run in two identical lanes in lockstep,
// each with one 26x32 multiplier that steps through the biquad cascade in six steps per
// active stage (b0*x, y, b1*x, a1*y, b2*x, a2*y), then through gain, magnitude, quantizing
// and output steps. On the last sample of a block the meters add a 48-bit divider and a
// 24-bit square root. One sample pair is worked at a time; in_stall stays high until its
// result is placed in the output register, which holds it while out_stall is high so the
// next transaction can already be taken. All coefficients must be written before the
// first sample pair; the coefficient memory has no reset. Configuration goes through the
// APB port; the user must write it only while idle, which the block does not enforce.
// prdata returns the register at paddr.
module stereo_biquad_eq_chain_with_meter #(
  parameter int BLOCK_LIMIT = sbeq_pkg::BLOCK_LIMIT_DEF,
  parameter int STAGE_COUNT = sbeq_pkg::STAGE_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sbeq_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic signed [15:0]                 in_left_sample,
  input  logic signed [15:0]                 in_right_sample,
  input  logic                               in_last_of_block,
  input  logic [4:0]                         in_coeff_index,
  input  logic signed [sbeq_pkg::COEF_W-1:0] in_coeff_value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [15:0]                 out_left,
  output logic signed [15:0]                 out_right,
  output logic                               out_levels_valid,
  output logic [15:0]                        out_rms_left,
  output logic [15:0]                        out_rms_right,
  output logic [15:0]                        out_peak_left,
  output logic [15:0]                        out_peak_right
);
  import sbeq_pkg::*;

  localparam int NCOEF = 5 * STAGE_COUNT;
  localparam int CIW   = $clog2(NCOEF);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_FILT  = 9'b000000010,
    ST_GAIN  = 9'b000000100,
    ST_MAG   = 9'b000001000,
    ST_QUANT = 9'b000010000,
    ST_OUT   = 9'b000100000,
    ST_METER = 9'b001000000,
    ST_WAIT  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  // config registers
  logic        hpf_r;
  logic        lpf_r;
  logic [16:0] gain_r;
  logic        mute_r;
  logic [15:0] decay_r;

  state_t              state_r, state_nxt;
  logic [3:0]          stg_r, stg_nxt;
  logic [2:0]          ph_r, ph_nxt;
  ctl_t                ctl_r, ctl_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                end_r, end_nxt;
  logic                last_r;
  logic signed [15:0]  smp_l_r, smp_r_r;

  logic signed [COEF_W-1:0] coef_mem [NCOEF];
  logic signed [COEF_W-1:0] coef_rd_r;
  logic [CIW-1:0]           coef_raddr;
  int                       coef_pos;

  logic                in_acc;
  logic                cfg_wr;
  logic                out_free;
  logic [3:0]          first_stg;
  logic [3:0]          after_stg;
  logic [CNT_W-1:0]    cnt1;
  logic                blk_end;

  logic signed [15:0]  lane_out_l, lane_out_r;
  logic [15:0]         level_l, level_r;
  logic                m_done_l, m_done_r;
  logic [15:0]         rms_l, rms_r, pk_l, pk_r;

  logic                out_valid_r;
  logic signed [15:0]  out_l_r, out_r_r;
  logic                out_lv_r;
  logic [15:0]         out_rms_l_r, out_rms_r_r, out_pk_l_r, out_pk_r_r;

  // skip the high-pass and low-pass stages when they are disabled
  function automatic logic [3:0] next_en(input logic [3:0] s, input logic hp,
                                         input logic lp);
    logic [3:0] c;
    c = s;
    if (c == 4'd0 && !hp) c = 4'd1;
    if (c == 4'd1 && !lp) c = 4'd2;
    return c;
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  assign first_stg = next_en(4'd0, hpf_r, lpf_r);
  assign after_stg = next_en(stg_r + 4'd1, hpf_r, lpf_r);
  assign cnt1      = count_r + CNT_W'(1);
  assign blk_end   = last_r || (cnt1 >= CNT_W'(BLOCK_LIMIT));

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpf_r   <= 1'b0;
      lpf_r   <= 1'b0;
      gain_r  <= 17'd32768;
      mute_r  <= 1'b0;
      decay_r <= 16'd62259;
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_HPF:   hpf_r   <= pwdata[0];
        REG_LPF:   lpf_r   <= pwdata[0];
        REG_GAIN:  gain_r  <= pwdata[16:0];
        REG_MUTE:  mute_r  <= pwdata[0];
        REG_DECAY: decay_r <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_HPF:   prdata = {31'b0, hpf_r};
      REG_LPF:   prdata = {31'b0, lpf_r};
      REG_GAIN:  prdata = {15'b0, gain_r};
      REG_MUTE:  prdata = {31'b0, mute_r};
      REG_DECAY: prdata = {16'b0, decay_r};
      default:   prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    stg_nxt   = stg_r;
    ph_nxt    = ph_r;
    count_nxt = count_r;
    end_nxt   = end_r;
    ctl_nxt   = '{op: OP_IDLE, stage: STG_W'(stg_r), phase: ph_r,
                  blk_end: blk_end, blk_count: cnt1};
    case (state_r)
      ST_IDLE: begin
        if (in_acc && !in_action) begin
          ctl_nxt.op = OP_LOAD;
          stg_nxt    = first_stg;
          ph_nxt     = PH_B0X;
          state_nxt  = (32'(first_stg) < STAGE_COUNT) ? ST_FILT : ST_GAIN;
        end
      end
      ST_FILT: begin
        ctl_nxt.op = OP_MAC;
        if (ph_r == PH_Z2) begin
          // advance to the next running stage or leave the cascade
          ph_nxt = PH_B0X;
          if (32'(after_stg) < STAGE_COUNT) begin
            stg_nxt = after_stg;
          end else begin
            state_nxt = ST_GAIN;
          end
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      ST_GAIN: begin
        ctl_nxt.op = OP_GAIN;
        state_nxt  = ST_MAG;
      end
      ST_MAG: begin
        ctl_nxt.op = OP_MAG;
        state_nxt  = ST_QUANT;
      end
      ST_QUANT: begin
        ctl_nxt.op = OP_QUANT;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        ctl_nxt.op = OP_OUT;
        state_nxt  = ST_METER;
      end
      ST_METER: begin
        // hand the level to the meters with this sample's count and block end
        ctl_nxt.op = OP_METER;
        end_nxt    = blk_end;
        count_nxt  = blk_end ? '0 : cnt1;
        state_nxt  = ST_WAIT;
      end
      ST_WAIT: begin
        if (m_done_l && m_done_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stg_r   <= '0;
      ph_r    <= PH_B0X;
      count_r <= '0;
      end_r   <= 1'b0;
      ctl_r   <= '{op: OP_IDLE, stage: '0, phase: PH_B0X, blk_end: 1'b0, blk_count: '0};
    end else begin
      state_r <= state_nxt;
      stg_r   <= stg_nxt;
      ph_r    <= ph_nxt;
      count_r <= count_nxt;
      end_r   <= end_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

  // hold the accepted sample pair for the load step
  always_ff @(posedge clk) begin
    if (in_acc && !in_action) begin
      smp_l_r <= in_left_sample;
      smp_r_r <= in_right_sample;
      last_r  <= in_last_of_block;
    end
  end

  // ---------------- coefficient memory ----------------
  // read in the cycle before the lane step that uses the value
  always_comb begin
    case (ctl_nxt.phase)
      PH_B0X:  coef_pos = POS_B0;
      PH_YOUT: coef_pos = POS_B1;
      PH_A1Y:  coef_pos = POS_A1;
      PH_Z1:   coef_pos = POS_B2;
      PH_A2Y:  coef_pos = POS_A2;
      default: coef_pos = POS_B0;
    endcase
  end

  assign coef_raddr = CIW'(32'(ctl_nxt.stage) * 5 + coef_pos);

  always_ff @(posedge clk) begin
    if (in_acc && in_action && (32'(in_coeff_index) < NCOEF)) begin
      coef_mem[CIW'(in_coeff_index)] <= in_coeff_value;
    end
    coef_rd_r <= coef_mem[coef_raddr];
  end

  // ---------------- lanes ----------------
  sbeq_lane #(.STAGE_COUNT(STAGE_COUNT)) u_lane_l (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl_r),
    .coef       (coef_rd_r),
    .sample     (smp_l_r),
    .gain       (gain_r),
    .mute       (mute_r),
    .out_sample (lane_out_l),
    .level      (level_l)
  );

  sbeq_lane #(.STAGE_COUNT(STAGE_COUNT)) u_lane_r (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl_r),
    .coef       (coef_rd_r),
    .sample     (smp_r_r),
    .gain       (gain_r),
    .mute       (mute_r),
    .out_sample (lane_out_r),
    .level      (level_r)
  );

  sbeq_meter u_meter_l (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctl_r.op == OP_METER),
    .blk_end   (ctl_r.blk_end),
    .blk_count (ctl_r.blk_count),
    .level     (level_l),
    .decay     (decay_r),
    .done      (m_done_l),
    .rms       (rms_l),
    .peak      (pk_l)
  );

  sbeq_meter u_meter_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctl_r.op == OP_METER),
    .blk_end   (ctl_r.blk_end),
    .blk_count (ctl_r.blk_count),
    .level     (level_r),
    .decay     (decay_r),
    .done      (m_done_r),
    .rms       (rms_r),
    .peak      (pk_r)
  );

  // ---------------- merge into the output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_l_r     <= lane_out_l;
      out_r_r     <= lane_out_r;
      out_lv_r    <= end_r;
      out_rms_l_r <= end_r ? rms_l : 16'd0;
      out_rms_r_r <= end_r ? rms_r : 16'd0;
      out_pk_l_r  <= end_r ? pk_l : 16'd0;
      out_pk_r_r  <= end_r ? pk_r : 16'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left         = out_l_r;
  assign out_right        = out_r_r;
  assign out_levels_valid = out_lv_r;
  assign out_rms_left     = out_rms_l_r;
  assign out_rms_right    = out_rms_r_r;
  assign out_peak_left    = out_pk_l_r;
  assign out_peak_right   = out_pk_r_r;

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    m_done_l == m_done_r)
    else $error("meter lanes out of step");
  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.op == OP_MAC) |-> (32'(ctl_r.stage) < STAGE_COUNT))
    else $error("stage index out of range");
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded");

endmodule
